// ----- sv/canvas_shape_fill_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// canvas_shape_fill_engine_top_macros
// Assertion helpers for the shape fill engine. Sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CANVAS_SHAPE_FILL_ENGINE_TOP_MACROS_SVH
`define CANVAS_SHAPE_FILL_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CSFE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CSFE_ASSERT_SAME(lbl, ante, cons, msg)
`define CSFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/csfe_pkg.sv -----
// ----------------------------------------------------------------------------
// csfe_pkg
// Shared types and constants of the shape fill engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csfe_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam int CANVAS_W = 8;
	localparam int COORD_W  = 12;
	localparam int SIZE_W   = 12;
	localparam int RADIUS_W = 11;
	localparam int COLOR_W  = 32;
	localparam int COUNT_W  = 15;
	localparam int CFG_IDX_W = 1;

	// signed width for box edges and distances from the shape origin
	localparam int DIFF_W = 14;
	// squared distances stay below 2**24
	localparam int SQ_W   = 24;

	localparam logic [CANVAS_W-1:0] CANVAS_RESET = 8'd128;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 15'h7FFF;

	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_RECT   = 2'd1,
		CMD_CIRCLE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// clipped box [xa,xb) x [ya,yb); for a read, xa/ya hold the pixel
	typedef struct packed {
		logic [CANVAS_W-1:0] xa;
		logic [CANVAS_W-1:0] xb;
		logic [CANVAS_W-1:0] ya;
		logic [CANVAS_W-1:0] yb;
		logic                empty;
		logic                inb;
	} bounds_t;

endpackage

`default_nettype wire

// ----- sv/csfe_frame_mem.sv -----
// ----------------------------------------------------------------------------
// csfe_frame_mem
// Frame store: one synchronous port, registered read data, no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfe_frame_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic                         re,
	input  logic [AW-1:0]                addr,
	input  logic [csfe_pkg::COLOR_W-1:0] wdata,
	output logic [csfe_pkg::COLOR_W-1:0] rdata
);
	import csfe_pkg::*;

	logic [COLOR_W-1:0] store_q [DEPTH];
	logic [COLOR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/csfe_clip.sv -----
// ----------------------------------------------------------------------------
// csfe_clip
// Builds the canvas-clipped bounding box of a request and the read bounds check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfe_clip #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic [csfe_pkg::CANVAS_W-1:0]    canvas_width,
	input  logic [csfe_pkg::CANVAS_W-1:0]    canvas_height,
	input  csfe_pkg::cmd_t                   command,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_x,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_y,
	input  logic [csfe_pkg::SIZE_W-1:0]      size_w,
	input  logic [csfe_pkg::SIZE_W-1:0]      size_h,
	input  logic [csfe_pkg::RADIUS_W-1:0]    radius,
	output csfe_pkg::bounds_t                bounds
);
	import csfe_pkg::*;

	function automatic logic [CANVAS_W-1:0] clamp_lim(input logic signed [DIFF_W-1:0] v,
		input logic [CANVAS_W-1:0] lim);
		logic signed [DIFF_W-1:0] lim_s;
		lim_s = $signed({{(DIFF_W-CANVAS_W){1'b0}}, lim});
		if (v < 0) begin
			return '0;
		end else if (v > lim_s) begin
			return lim;
		end else begin
			return v[CANVAS_W-1:0];
		end
	endfunction

	logic [CANVAS_W-1:0]      eff_w, eff_h;
	logic signed [DIFF_W-1:0] w_e, h_e, px_e, py_e, sw_e, sh_e, r_e;
	logic signed [DIFF_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic [CANVAS_W-1:0]      xa, xb, ya, yb;

	// canvas registers larger than the store act as the store size
	assign eff_w = (32'(canvas_width) > 32'(MAX_WIDTH)) ? CANVAS_W'(MAX_WIDTH) : canvas_width;
	assign eff_h = (32'(canvas_height) > 32'(MAX_HEIGHT)) ? CANVAS_W'(MAX_HEIGHT) : canvas_height;

	assign w_e  = $signed({{(DIFF_W-CANVAS_W){1'b0}}, eff_w});
	assign h_e  = $signed({{(DIFF_W-CANVAS_W){1'b0}}, eff_h});
	assign px_e = DIFF_W'(pos_x);
	assign py_e = DIFF_W'(pos_y);
	assign sw_e = $signed({{(DIFF_W-SIZE_W){1'b0}}, size_w});
	assign sh_e = $signed({{(DIFF_W-SIZE_W){1'b0}}, size_h});
	assign r_e  = $signed({{(DIFF_W-RADIUS_W){1'b0}}, radius});

	always_comb begin
		unique case (command)
			CMD_CLEAR: begin
				lo_x = '0;
				hi_x = w_e;
				lo_y = '0;
				hi_y = h_e;
			end
			CMD_RECT: begin
				lo_x = px_e;
				hi_x = px_e + sw_e;
				lo_y = py_e;
				hi_y = py_e + sh_e;
			end
			CMD_CIRCLE: begin
				lo_x = px_e - r_e;
				hi_x = px_e + r_e + 14'sd1;
				lo_y = py_e - r_e;
				hi_y = py_e + r_e + 14'sd1;
			end
			CMD_READ: begin
				// clamp passes an in-canvas pixel through unchanged
				lo_x = px_e;
				hi_x = px_e + 14'sd1;
				lo_y = py_e;
				hi_y = py_e + 14'sd1;
			end
		endcase
	end

	assign xa = clamp_lim(lo_x, eff_w);
	assign xb = clamp_lim(hi_x, eff_w);
	assign ya = clamp_lim(lo_y, eff_h);
	assign yb = clamp_lim(hi_y, eff_h);

	always_comb begin
		bounds.xa    = xa;
		bounds.xb    = xb;
		bounds.ya    = ya;
		bounds.yb    = yb;
		bounds.empty = (xa >= xb) || (ya >= yb);
		bounds.inb   = (command == CMD_READ) && (px_e >= 0) && (px_e < w_e)
			&& (py_e >= 0) && (py_e < h_e);
	end

endmodule

`default_nettype wire

// ----- sv/csfe_seq.sv -----
// ----------------------------------------------------------------------------
// csfe_seq
// Request sequencer: latches a request, walks the clipped box one pixel per
// cycle with incremental squared distances, drives the frame store, returns
// one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfe_seq #(
	parameter int MAX_WIDTH  = 128,
	parameter int AW         = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          command,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_x,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_y,
	input  logic [csfe_pkg::SIZE_W-1:0]         size_w,
	input  logic [csfe_pkg::SIZE_W-1:0]         size_h,
	input  logic [csfe_pkg::RADIUS_W-1:0]       radius,
	input  logic [csfe_pkg::COLOR_W-1:0]        fill_color,
	output logic                                busy,
	// latched request, to the clipper
	output csfe_pkg::cmd_t                      op_cmd,
	output logic signed [csfe_pkg::COORD_W-1:0] op_pos_x,
	output logic signed [csfe_pkg::COORD_W-1:0] op_pos_y,
	output logic [csfe_pkg::SIZE_W-1:0]         op_size_w,
	output logic [csfe_pkg::SIZE_W-1:0]         op_size_h,
	output logic [csfe_pkg::RADIUS_W-1:0]       op_radius,
	input  csfe_pkg::bounds_t                   bounds,
	// frame store
	output logic                                mem_we,
	output logic                                mem_re,
	output logic [AW-1:0]                       mem_addr,
	output logic [csfe_pkg::COLOR_W-1:0]        mem_wdata,
	input  logic [csfe_pkg::COLOR_W-1:0]        mem_rdata,
	// result
	output logic                                done,
	output logic [csfe_pkg::COLOR_W-1:0]        read_color,
	output logic                                in_bounds,
	output logic [csfe_pkg::COUNT_W-1:0]        pixels_written
);
	import csfe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_INIT,
		ST_SCAN,
		ST_RDREQ,
		ST_RDRESP
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SIZE_W-1:0]        sw_q, sh_q;
	logic [RADIUS_W-1:0]      r_q;
	logic [COLOR_W-1:0]       color_q;
	bounds_t                  bnd_q;
	logic [CANVAS_W-1:0]      x_q, y_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q, dx0_q;
	logic [SQ_W-1:0]          dxsq_q, dysq_q, dx0sq_q, rsq_q;
	logic [AW-1:0]            row_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     done_q;
	logic [COLOR_W-1:0]       read_color_q;
	logic                     in_bounds_q;
	logic [COUNT_W-1:0]       pixels_written_q;

	logic signed [DIFF_W-1:0]   dx_init, dy_init;
	logic signed [2*DIFF_W-1:0] dx_prod, dy_prod;
	logic [2*RADIUS_W-1:0]      r_prod;
	logic [AW-1:0]              row_init;
	logic [SQ_W-1:0]            dx_step, dy_step;
	logic                       in_disc, x_last, y_last;
	logic [COUNT_W-1:0]         cnt_next;
	logic [AW+CANVAS_W-1:0]     addr_sum;

	// start-of-box offsets and their squares, formed once per request
	assign dx_init  = $signed({{(DIFF_W-CANVAS_W){1'b0}}, bnd_q.xa}) - DIFF_W'(px_q);
	assign dy_init  = $signed({{(DIFF_W-CANVAS_W){1'b0}}, bnd_q.ya}) - DIFF_W'(py_q);
	assign dx_prod  = dx_init * dx_init;
	assign dy_prod  = dy_init * dy_init;
	assign r_prod   = r_q * r_q;
	assign row_init = AW'(32'(bnd_q.ya) * 32'(MAX_WIDTH));

	// (d+1)^2 = d^2 + 2d + 1
	assign dx_step = SQ_W'($signed({dx_q, 1'b1}));
	assign dy_step = SQ_W'($signed({dy_q, 1'b1}));

	assign in_disc = (cmd_q != CMD_CIRCLE)
		|| (({1'b0, dxsq_q} + {1'b0, dysq_q}) <= {1'b0, rsq_q});
	assign x_last = ({1'b0, x_q} + 9'd1) == {1'b0, bnd_q.xb};
	assign y_last = ({1'b0, y_q} + 9'd1) == {1'b0, bnd_q.yb};
	assign cnt_next = (in_disc && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;

	assign addr_sum  = (AW+CANVAS_W)'(row_q) + (AW+CANVAS_W)'(x_q);
	assign mem_addr  = addr_sum[AW-1:0];
	assign mem_wdata = color_q;
	assign mem_we    = (state_q == ST_SCAN) && in_disc;
	assign mem_re    = (state_q == ST_RDREQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			cmd_q            <= CMD_CLEAR;
			px_q             <= '0;
			py_q             <= '0;
			sw_q             <= '0;
			sh_q             <= '0;
			r_q              <= '0;
			color_q          <= '0;
			bnd_q            <= '0;
			x_q              <= '0;
			y_q              <= '0;
			dx_q             <= '0;
			dy_q             <= '0;
			dx0_q            <= '0;
			dxsq_q           <= '0;
			dysq_q           <= '0;
			dx0sq_q          <= '0;
			rsq_q            <= '0;
			row_q            <= '0;
			count_q          <= '0;
			done_q           <= 1'b0;
			read_color_q     <= '0;
			in_bounds_q      <= 1'b0;
			pixels_written_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(command);
						px_q    <= pos_x;
						py_q    <= pos_y;
						sw_q    <= size_w;
						sh_q    <= size_h;
						r_q     <= radius;
						color_q <= fill_color;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					bnd_q   <= bounds;
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					x_q     <= bnd_q.xa;
					y_q     <= bnd_q.ya;
					dx_q    <= dx_init;
					dx0_q   <= dx_init;
					dy_q    <= dy_init;
					dxsq_q  <= dx_prod[SQ_W-1:0];
					dx0sq_q <= dx_prod[SQ_W-1:0];
					dysq_q  <= dy_prod[SQ_W-1:0];
					rsq_q   <= SQ_W'(r_prod);
					row_q   <= row_init;
					count_q <= '0;
					if (cmd_q == CMD_READ) begin
						if (bnd_q.inb) begin
							state_q <= ST_RDREQ;
						end else begin
							read_color_q     <= '0;
							in_bounds_q      <= 1'b0;
							pixels_written_q <= '0;
							done_q           <= 1'b1;
							state_q          <= ST_IDLE;
						end
					end else if (bnd_q.empty) begin
						read_color_q     <= '0;
						in_bounds_q      <= 1'b0;
						pixels_written_q <= '0;
						done_q           <= 1'b1;
						state_q          <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					count_q <= cnt_next;
					if (x_last) begin
						if (y_last) begin
							read_color_q     <= '0;
							in_bounds_q      <= 1'b0;
							pixels_written_q <= cnt_next;
							done_q           <= 1'b1;
							state_q          <= ST_IDLE;
						end else begin
							x_q    <= bnd_q.xa;
							dx_q   <= dx0_q;
							dxsq_q <= dx0sq_q;
							y_q    <= y_q + 1'b1;
							dy_q   <= dy_q + 14'sd1;
							dysq_q <= dysq_q + dy_step;
							row_q  <= row_q + AW'(MAX_WIDTH);
						end
					end else begin
						x_q    <= x_q + 1'b1;
						dx_q   <= dx_q + 14'sd1;
						dxsq_q <= dxsq_q + dx_step;
					end
				end
				ST_RDREQ: begin
					state_q <= ST_RDRESP;
				end
				ST_RDRESP: begin
					read_color_q     <= mem_rdata;
					in_bounds_q      <= 1'b1;
					pixels_written_q <= '0;
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign op_cmd         = cmd_q;
	assign op_pos_x       = px_q;
	assign op_pos_y       = py_q;
	assign op_size_w      = sw_q;
	assign op_size_h      = sh_q;
	assign op_radius      = r_q;
	assign done           = done_q;
	assign read_color     = read_color_q;
	assign in_bounds      = in_bounds_q;
	assign pixels_written = pixels_written_q;

endmodule

`default_nettype wire

// ----- sv/canvas_shape_fill_engine_top.sv -----
// ----------------------------------------------------------------------------
// canvas_shape_fill_engine_top
// 2D fill engine over a 32-bit frame store: clear, rectangle, disc, pixel read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// the result goes out. Each request yields one result, shown for exactly one
// cycle with done high; the receiver cannot stall it, so it must take it then.
// Timing is set by the single frame store port, one pixel per cycle: a draw
// passes setup and init, then scans the clipped box; an empty or fully
// clipped draw ends in init, a read goes on through request and response
// (ends in init when out of canvas). busy drops in the done cycle, so the
// next request may be taken there. The store is not cleared by reset: clear
// the canvas before reading. Canvas size writes belong between requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "canvas_shape_fill_engine_top_macros.svh"

module canvas_shape_fill_engine_top #(
	parameter int MAX_WIDTH  = csfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = csfe_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csfe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [csfe_pkg::CANVAS_W-1:0]       cfg_data,
	input  logic                                start,
	input  logic [1:0]                          command,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_x,
	input  logic signed [csfe_pkg::COORD_W-1:0] pos_y,
	input  logic [csfe_pkg::SIZE_W-1:0]         size_w,
	input  logic [csfe_pkg::SIZE_W-1:0]         size_h,
	input  logic [csfe_pkg::RADIUS_W-1:0]       radius,
	input  logic [csfe_pkg::COLOR_W-1:0]        fill_color,
	output logic                                busy,
	output logic                                done,
	output logic [csfe_pkg::COLOR_W-1:0]        read_color,
	output logic                                in_bounds,
	output logic [csfe_pkg::COUNT_W-1:0]        pixels_written
);
	import csfe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [CANVAS_W-1:0]       canvas_width_q, canvas_height_q;
	cmd_t                      op_cmd;
	logic signed [COORD_W-1:0] op_pos_x, op_pos_y;
	logic [SIZE_W-1:0]         op_size_w, op_size_h;
	logic [RADIUS_W-1:0]       op_radius;
	bounds_t                   bounds;
	logic                      mem_we, mem_re;
	logic [AW-1:0]             mem_addr;
	logic [COLOR_W-1:0]        mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= CANVAS_RESET;
			canvas_height_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data;
				CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	csfe_clip #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_clip (
		.canvas_width (canvas_width_q),
		.canvas_height(canvas_height_q),
		.command      (op_cmd),
		.pos_x        (op_pos_x),
		.pos_y        (op_pos_y),
		.size_w       (op_size_w),
		.size_h       (op_size_h),
		.radius       (op_radius),
		.bounds       (bounds)
	);

	csfe_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.command       (command),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.size_w        (size_w),
		.size_h        (size_h),
		.radius        (radius),
		.fill_color    (fill_color),
		.busy          (busy),
		.op_cmd        (op_cmd),
		.op_pos_x      (op_pos_x),
		.op_pos_y      (op_pos_y),
		.op_size_w     (op_size_w),
		.op_size_h     (op_size_h),
		.op_radius     (op_radius),
		.bounds        (bounds),
		.mem_we        (mem_we),
		.mem_re        (mem_re),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata),
		.done          (done),
		.read_color    (read_color),
		.in_bounds     (in_bounds),
		.pixels_written(pixels_written)
	);

	csfe_frame_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_frame_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// an accepted request goes busy before its result
	`CSFE_ASSERT_NEXT(a_done_single, done, !done, "done held two cycles")
	`CSFE_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")
	`CSFE_ASSERT_SAME(a_read_no_count, done && in_bounds, pixels_written == '0,
		"read result carries a pixel count")
	`CSFE_ASSERT_SAME(a_write_in_request, mem_we, busy && !mem_re,
		"frame store write outside a draw")

endmodule

`default_nettype wire
